// ===== rtl/core/ssao_pkg.sv =====
// ssao_pkg: shared types, constants and fixed-point helpers for the speed and angle observer
// no dependencies; imported by every module in rtl/core
package ssao_pkg;

  // apb address width, registers at byte address 4*i
  localparam int ADDR_W = 5;

  // angle wrap constants, q16.16
  localparam int Q_PI     = 205887;
  localparam int Q_TWO_PI = 411775;

  // restoring reduction steps: 2^(WRAP_STEPS) * two_pi covers the biased angle range
  localparam int WRAP_STEPS = 14;
  localparam int WRAP_CNT_W = 4;
  localparam int WRAP_W     = 33;

  // bias of 8192 * two_pi keeps the value to be reduced positive
  localparam logic signed [34:0] WRAP_BIAS = 35'sd3373260800;

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  typedef enum logic [2:0] {
    REG_RESISTANCE = 3'd0,
    REG_Q_IND      = 3'd1,
    REG_INV_KE     = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_BASE_BW    = 3'd4,
    REG_LAMBDA     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] stator_resistance;
    logic [31:0] q_inductance;
    logic [31:0] inverse_emf_constant;
    logic [31:0] sample_period;
    logic [31:0] base_bandwidth;
    logic [3:0]  lambda_gain;
  } cfg_t;

  // request to the shared multiplier
  typedef struct packed {
    logic              en;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // round half up, then floor shift by 16
  function automatic logic signed [49:0] rnd16(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + 66'sd32768;
    return t[65:16];
  endfunction

  // round half up, then floor shift by 32
  function automatic logic signed [33:0] rnd32(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + 66'sd2147483648;
    return t[65:32];
  endfunction

endpackage

// ===== rtl/core/ssao_mul.sv =====
// ssao_mul: shared 33 x 33 signed multiplier with registered product
// depends on ssao_pkg (mul_req_t)
module ssao_mul (
  input  logic                clk,
  input  ssao_pkg::mul_req_t  req,
  output logic signed [65:0]  prod
);
  import ssao_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

// ===== rtl/core/ssao_wrap.sv =====
// ssao_wrap: iterative restoring reduction of the biased angle modulo two_pi
// depends on ssao_pkg (wrap constants)
module ssao_wrap (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ssao_pkg::WRAP_W-1:0] value,
  output logic                      done,
  output logic signed [18:0]        angle
);
  import ssao_pkg::*;

  logic [WRAP_W-1:0]     rem;
  logic [WRAP_CNT_W-1:0] cnt;
  logic                  busy;
  logic [WRAP_W-1:0]     step_sub;
  logic signed [19:0]    centered;

  // one shifted multiple of two_pi per cycle, largest first
  assign step_sub = WRAP_W'(Q_TWO_PI) << cnt;
  assign centered = $signed({1'b0, rem[18:0]}) - 20'sd205887;
  assign angle    = centered[18:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= value;
        cnt  <= WRAP_CNT_W'(WRAP_STEPS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= step_sub) begin
          rem <= rem - step_sub;
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ssao_regs.sv =====
// ssao_regs: apb configuration registers of the observer
// depends on ssao_pkg (cfg_t, reg_idx_t, ADDR_W)
module ssao_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssao_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ssao_pkg::cfg_t              cfg
);
  import ssao_pkg::*;

  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stator_resistance    <= 32'd0;
      cfg.q_inductance         <= 32'd0;
      cfg.inverse_emf_constant <= 32'd65536;
      cfg.sample_period        <= 32'd0;
      cfg.base_bandwidth       <= 32'd0;
      cfg.lambda_gain          <= 4'd2;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_RESISTANCE: cfg.stator_resistance    <= pwdata;
        REG_Q_IND:      cfg.q_inductance         <= pwdata;
        REG_INV_KE:     cfg.inverse_emf_constant <= pwdata;
        REG_PERIOD:     cfg.sample_period        <= pwdata;
        REG_BASE_BW:    cfg.base_bandwidth       <= pwdata;
        REG_LAMBDA:     cfg.lambda_gain          <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESISTANCE: prdata = cfg.stator_resistance;
      REG_Q_IND:      prdata = cfg.q_inductance;
      REG_INV_KE:     prdata = cfg.inverse_emf_constant;
      REG_PERIOD:     prdata = cfg.sample_period;
      REG_BASE_BW:    prdata = cfg.base_bandwidth;
      REG_LAMBDA:     prdata = {28'd0, cfg.lambda_gain};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/sensorless_speed_angle_observer_core.sv =====
// sensorless_speed_angle_observer_core: top level of the voltage-model speed and angle observer
// depends on ssao_pkg, ssao_regs, ssao_mul, ssao_wrap
//
//  channel  | signals                                   | direction | moves
//  ---------+-------------------------------------------+-----------+---------------------------
//  input    | in_valid, in_ready, volt_d/q, curr_d/q    | in        | one control period request
//  output   | out_valid, out_ready, speed/angle_estimate| out       | updated speed and angle
//  config   | psel, penable, pwrite, paddr, pwdata,     | in/out    | register writes and reads
//           | prdata, pready                            |           |
//
// sequence: an accepted request runs through 14 sequencer steps (11 of them on the shared
//   multiplier), then waits on the angle wrap (14 reduction steps and its done flag),
//   then the output load
// the next request is taken in the cycle after the result is loaded, so only one is in flight
// reset: synchronous; clears speed and angle state, the sequencer and the output valid;
//   registers return to their reset values
// stalls: a held result keeps the sequencer in its output step until out_ready
module sensorless_speed_angle_observer_core (
  input  logic                        clk,
  input  logic                        rst,
  // input request
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          volt_d,
  input  logic signed [31:0]          volt_q,
  input  logic signed [31:0]          curr_d,
  input  logic signed [31:0]          curr_q,
  // result
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          speed_estimate,
  output logic signed [18:0]          angle_estimate,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssao_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ssao_pkg::*;

  // one step per multiplier use; names follow the product issued or the value formed in that step
  typedef enum logic [4:0] {
    S_IDLE,
    S_WL,       // issue w * lq
    S_RCD,      // take wl, issue r * id
    S_WLCQ,     // vd - r*id, issue wl * iq
    S_RCQ,      // d emf, issue r * iq
    S_WLCD,     // vq - r*iq, issue wl * id
    S_QEMF,     // q emf, issue lambda * d emf
    S_ERR,      // error term, issue lambda * |w|
    S_BW,       // bandwidth, issue err * inv ke
    S_TGT,      // target speed, issue ts * bw
    S_GAIN,     // filter gain and speed difference
    S_UPD,      // issue diff * gain
    S_SPEED,    // new speed
    S_ANG_MUL,  // issue w' * ts
    S_ANG,      // angle sum into the wrap unit
    S_WRAP,     // wait for the reduction
    S_OUT       // load result once the output register is free
  } state_t;

  state_t             state;
  cfg_t               cfg;
  mul_req_t           mreq;
  logic signed [65:0] prod;

  // latched request
  logic signed [31:0] vd, vq, cd, cq;

  // model state
  logic signed [31:0] speed_reg;
  logic signed [18:0] angle_reg;

  // intermediates
  logic signed [51:0] acc;
  logic signed [31:0] wl, demf, qemf, err, tgt, diff, speed_new;
  logic [31:0]        bw, gain;
  logic signed [32:0] abs_w;
  logic [37:0]        bw_sum;
  logic [65:0]        gain_sum;
  logic signed [34:0] ang_sum;

  // result load from the output step
  logic               load_out;

  // wrap unit
  logic               wrap_start;
  logic               wrap_done;
  logic signed [18:0] wrap_angle;

  ssao_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssao_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  ssao_wrap u_wrap (
    .clk   (clk),
    .rst   (rst),
    .start (wrap_start),
    .value (ang_sum[WRAP_W-1:0]),
    .done  (wrap_done),
    .angle (wrap_angle)
  );

  assign in_ready   = (state == S_IDLE);
  assign wrap_start = (state == S_ANG);
  assign load_out   = (state == S_OUT) && (!out_valid || out_ready);

  assign abs_w    = speed_reg[31] ? -33'(speed_reg) : 33'(speed_reg);
  // base + 2*lambda*|w|, product is non-negative and below 2^36
  assign bw_sum   = 38'(cfg.base_bandwidth) + {prod[36:0], 1'b0};
  assign gain_sum = prod + 66'd2147483648;
  // biased angle: angle + round(w'*ts) + pi + 8192*two_pi, always positive
  assign ang_sum  = 35'(angle_reg) + 35'(rnd32(prod)) + 35'(Q_PI) + WRAP_BIAS;

  // multiplier operand select
  always_comb begin
    mreq.en = 1'b1;
    mreq.a  = '0;
    mreq.b  = '0;
    case (state)
      S_WL: begin
        mreq.a = 33'(speed_reg);
        mreq.b = {1'b0, cfg.q_inductance};
      end
      S_RCD: begin
        mreq.a = {1'b0, cfg.stator_resistance};
        mreq.b = 33'(cd);
      end
      S_WLCQ: begin
        mreq.a = 33'(wl);
        mreq.b = 33'(cq);
      end
      S_RCQ: begin
        mreq.a = {1'b0, cfg.stator_resistance};
        mreq.b = 33'(cq);
      end
      S_WLCD: begin
        mreq.a = 33'(wl);
        mreq.b = 33'(cd);
      end
      S_QEMF: begin
        mreq.a = 33'(demf);
        mreq.b = {29'd0, cfg.lambda_gain};
      end
      S_ERR: begin
        mreq.a = abs_w;
        mreq.b = {29'd0, cfg.lambda_gain};
      end
      S_BW: begin
        mreq.a = 33'(err);
        mreq.b = {1'b0, cfg.inverse_emf_constant};
      end
      S_TGT: begin
        mreq.a = {1'b0, cfg.sample_period};
        mreq.b = {1'b0, bw};
      end
      S_UPD: begin
        mreq.a = 33'(diff);
        mreq.b = {1'b0, gain};
      end
      S_ANG_MUL: begin
        mreq.a = 33'(speed_new);
        mreq.b = {1'b0, cfg.sample_period};
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      speed_reg <= '0;
      angle_reg <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            vd    <= volt_d;
            vq    <= volt_q;
            cd    <= curr_d;
            cq    <= curr_q;
            state <= S_WL;
          end
        end
        S_WL: state <= S_RCD;
        S_RCD: begin
          // |w*lq| >> 32 stays within 32 bits
          wl    <= 32'(rnd32(prod));
          state <= S_WLCQ;
        end
        S_WLCQ: begin
          acc   <= 52'(vd) - 52'(rnd16(prod));
          state <= S_RCQ;
        end
        S_RCQ: begin
          demf  <= sat32(acc + 52'(rnd16(prod)));
          state <= S_WLCD;
        end
        S_WLCD: begin
          acc   <= 52'(vq) - 52'(rnd16(prod));
          state <= S_QEMF;
        end
        S_QEMF: begin
          qemf  <= sat32(acc - 52'(rnd16(prod)));
          state <= S_ERR;
        end
        S_ERR: begin
          // cross term sign follows the old angle
          if (angle_reg[18]) begin
            err <= sat32(52'(qemf) + 52'(prod));
          end else begin
            err <= sat32(52'(qemf) - 52'(prod));
          end
          state <= S_BW;
        end
        S_BW: begin
          bw    <= (bw_sum[37:32] != 6'd0) ? 32'hffffffff : bw_sum[31:0];
          state <= S_TGT;
        end
        S_TGT: begin
          tgt   <= sat32(52'(rnd16(prod)));
          state <= S_GAIN;
        end
        S_GAIN: begin
          // ts*bw is below 2^64, so the rounded gain fits 32 bits
          gain  <= gain_sum[63:32];
          diff  <= sat32(52'(tgt) - 52'(speed_reg));
          state <= S_UPD;
        end
        S_UPD: state <= S_SPEED;
        S_SPEED: begin
          speed_new <= sat32(52'(speed_reg) + 52'(rnd16(prod)));
          state     <= S_ANG_MUL;
        end
        S_ANG_MUL: state <= S_ANG;
        S_ANG:     state <= S_WRAP;
        S_WRAP: begin
          if (wrap_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            speed_estimate <= speed_new;
            angle_estimate <= wrap_angle;
            speed_reg      <= speed_new;
            angle_reg      <= wrap_angle;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a request is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while the sequencer was busy");

  // a new result is only loaded from the output step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result appeared outside the output step");

  // wrapped angle lies in [-pi, pi]
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_estimate <= 19'sd205887) && (angle_estimate >= -19'sd205887))
    else $error("angle estimate left the wrap range");

  // the wrap unit only reports back while the sequencer waits for it
  a_wrap_done: assert property (@(posedge clk) disable iff (rst)
    wrap_done |-> (state == S_WRAP))
    else $error("wrap unit finished outside its wait step");

endmodule

// ===== tb/sensorless_speed_angle_observer_core_tb.sv =====
`timescale 1ns / 1ps
// sensorless_speed_angle_observer_core_tb: self-checking bench for the speed and angle observer
// drives requests and apb register writes, keeps its own fixed-point model, checks each result
// depends on ssao_pkg and sensorless_speed_angle_observer_core
module sensorless_speed_angle_observer_core_tb;
  import ssao_pkg::*;

  // run shape
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SEG_ITEMS      = 158;   // requests per random setting
  localparam int SEGS_PER_PHASE = 4;
  localparam int PRESSURE_AT    = 1320;  // accepted requests before the long output stall
  localparam int PRESSURE_HOLD  = 400;
  localparam int DRAIN_CYCLES   = 40;

  // unmapped register slot, writes there must not disturb anything
  localparam logic [2:0] SPARE_REG_IDX = 3'd6;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
  localparam int VOLT_SPAN = 32'h0190_0000;  // about 400 V
  localparam int CURR_SPAN = 32'h0032_0000;  // about 50 A

  // register settings used by the directed rows
  typedef enum int {KEEP_CFG, CFG_TRACK, CFG_MAXED, CFG_ZEROED, CFG_TYPICAL} cfg_pick_t;

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [18:0] angle;
  } estimate_t;

  typedef struct {
    cfg_pick_t          pick;
    logic signed [31:0] vd, vq, cd, cq;
    bit                 typed;
    logic signed [31:0] speed;
    logic signed [18:0] angle;
  } stim_row_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic signed [31:0]  volt_d    = '0;
  logic signed [31:0]  volt_q    = '0;
  logic signed [31:0]  curr_d    = '0;
  logic signed [31:0]  curr_q    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [31:0]  speed_estimate;
  logic signed [18:0]  angle_estimate;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  // typed-in expectation that travels with the request on the input port
  logic                row_typed = 1'b0;
  logic signed [31:0]  row_speed = '0;
  logic signed [18:0]  row_angle = '0;

  // observer model state and its copy of the registers
  cfg_t      obs_cfg;
  longint    speed_st;
  longint    angle_st;
  estimate_t estimate_q[$];

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int in_count      = 0;
  int mismatch_cnt  = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;

  stim_row_t directed_rows[$];

  sensorless_speed_angle_observer_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .volt_d         (volt_d),
    .volt_q         (volt_q),
    .curr_d         (curr_d),
    .curr_q         (curr_q),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .speed_estimate (speed_estimate),
    .angle_estimate (angle_estimate),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // fixed-point observer model
  // ---------------------------------------------------------------------------

  // round half up, then floor shift
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // one control period: back-emf, speed filter, angle integration and wrap
  function automatic estimate_t estimate_next(input logic signed [31:0] vd_in,
                                              input logic signed [31:0] vq_in,
                                              input logic signed [31:0] cd_in,
                                              input logic signed [31:0] cq_in);
    estimate_t       r;
    longint          vd, vq, cd, cq, w, lam, res, lq, ike, ts, base;
    longint          wl, demf, qemf, err, tgt, diff, absw, ang;
    longint unsigned bw, g, ts_u;
    vd   = vd_in;
    vq   = vq_in;
    cd   = cd_in;
    cq   = cq_in;
    w    = speed_st;
    lam  = {60'd0, obs_cfg.lambda_gain};
    res  = {32'd0, obs_cfg.stator_resistance};
    lq   = {32'd0, obs_cfg.q_inductance};
    ike  = {32'd0, obs_cfg.inverse_emf_constant};
    ts   = {32'd0, obs_cfg.sample_period};
    base = {32'd0, obs_cfg.base_bandwidth};

    // speed times lq feeds the cross-coupling terms
    wl   = clamp32(round_shift(w * lq, 32));
    demf = clamp32(vd - round_shift(res * cd, 16) + round_shift(wl * cq, 16));
    qemf = clamp32(vq - round_shift(res * cq, 16) - round_shift(wl * cd, 16));

    // cross term sign follows the sign of the old angle, zero counts as positive
    if (angle_st >= 0) begin
      err = clamp32(qemf - lam * demf);
    end else begin
      err = clamp32(qemf + lam * demf);
    end
    tgt = clamp32(round_shift(err * ike, 16));

    // bandwidth grows with |speed|, gain is ts * bw in q16.16
    absw = (w < 0) ? -w : w;
    bw   = base + 2 * lam * absw;
    if (bw > 64'hffff_ffff) bw = 64'hffff_ffff;
    ts_u = ts;
    g    = (ts_u * bw + 64'h8000_0000) >> 32;
    if (g > 64'hffff_ffff) g = 64'hffff_ffff;

    diff = clamp32(tgt - w);
    w    = clamp32(w + round_shift(diff * longint'(g), 16));

    // integrate and fold back into [-pi, pi], several turns at once if needed
    ang = angle_st + round_shift(w * ts, 32);
    if (ang > Q_PI) ang -= ((ang - Q_PI + Q_TWO_PI - 1) / Q_TWO_PI) * Q_TWO_PI;
    if (ang < -Q_PI) ang += ((-Q_PI - ang + Q_TWO_PI - 1) / Q_TWO_PI) * Q_TWO_PI;

    speed_st = w;
    angle_st = ang;
    r.speed  = w[31:0];
    r.angle  = ang[18:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cfg_t cfg_for(input cfg_pick_t p);
    cfg_t c;
    case (p)
      CFG_TRACK: begin
        // gain near one, so the speed jumps straight to its target
        c = '{32'h0001_0000, 32'h0100_0000, 32'h0001_0000, 32'hffff_ffff, 32'h0001_0000, 4'd3};
      end
      CFG_MAXED: begin
        c = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd15};
      end
      CFG_ZEROED: begin
        c = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'd0};
      end
      default: begin
        // 0.25 ohm, 0.625 mh, ke 2, 100 us period, 100 rad/s
        c = '{32'h0000_4000, 32'h0028_f5c3, 32'h0000_8000, 32'h0006_8db9, 32'h0064_0000, 4'd2};
      end
    endcase
    return c;
  endfunction

  function automatic logic [31:0] wild_word();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t random_cfg(input bit wild);
    cfg_t c;
    if (wild) begin
      c.stator_resistance    = wild_word();
      c.q_inductance         = wild_word();
      c.inverse_emf_constant = wild_word();
      c.sample_period        = wild_word();
      c.base_bandwidth       = wild_word();
    end else begin
      // plausible drive: small resistance and inductance, periods of about 15 to 244 us
      c.stator_resistance    = $urandom_range(32'h0004_0000);
      c.q_inductance         = $urandom_range(32'h0100_0000);
      c.inverse_emf_constant = $urandom_range(32'h0008_0000, 32'h0000_1000);
      c.sample_period        = $urandom_range(32'h0010_0000, 32'h0001_0000);
      c.base_bandwidth       = $urandom_range(32'h03e8_0000);
    end
    c.lambda_gain = $urandom_range(15);
    return c;
  endfunction

  function automatic logic signed [31:0] rand_span(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] rand_word(input int span);
    case ($urandom_range(15))
      0: return W_MAX;
      1: return W_MIN;
      2, 3: return $urandom;
      default: return rand_span(span);
    endcase
  endfunction

  function automatic void add_row(input cfg_pick_t pick,
                                  input logic signed [31:0] vd, input logic signed [31:0] vq,
                                  input logic signed [31:0] cd, input logic signed [31:0] cq,
                                  input bit typed);
    stim_row_t r;
    r.pick  = pick;
    r.vd    = vd;
    r.vq    = vq;
    r.cd    = cd;
    r.cq    = cq;
    r.typed = typed;
    // typed rows all run with a zero sample period, so nothing moves
    r.speed = '0;
    r.angle = '0;
    directed_rows.push_back(r);
  endfunction

  // apb write: setup cycle, then access until pready
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RESISTANCE: obs_cfg.stator_resistance    = data;
      REG_Q_IND:      obs_cfg.q_inductance         = data;
      REG_INV_KE:     obs_cfg.inverse_emf_constant = data;
      REG_PERIOD:     obs_cfg.sample_period        = data;
      REG_BASE_BW:    obs_cfg.base_bandwidth       = data;
      REG_LAMBDA:     obs_cfg.lambda_gain          = data[3:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input cfg_t c);
    logic [31:0] lam_word;
    lam_word      = $urandom;  // junk above the 4 lambda bits must be dropped
    lam_word[3:0] = c.lambda_gain;
    apb_write(REG_RESISTANCE, c.stator_resistance);
    apb_write(REG_Q_IND,      c.q_inductance);
    apb_write(REG_INV_KE,     c.inverse_emf_constant);
    apb_write(REG_PERIOD,     c.sample_period);
    apb_write(REG_BASE_BW,    c.base_bandwidth);
    apb_write(REG_LAMBDA,     lam_word);
  endtask

  // registers only change with nothing in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (estimate_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // offer one request, with a random gap in front of it
  task automatic send_request(input logic signed [31:0] vd, input logic signed [31:0] vq,
                              input logic signed [31:0] cd, input logic signed [31:0] cq,
                              input bit typed, input logic signed [31:0] speed,
                              input logic signed [18:0] angle);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid  <= 1'b1;
    volt_d    <= vd;
    volt_q    <= vq;
    curr_d    <= cd;
    curr_q    <= cq;
    row_typed <= typed;
    row_speed <= speed;
    row_angle <= angle;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: model each accepted request, check each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    estimate_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = estimate_next(volt_d, volt_q, curr_d, curr_q);
        // typed rows carry their own expectation, the model state still advances
        if (row_typed) begin
          want.speed = row_speed;
          want.angle = row_angle;
        end
        estimate_q.push_back(want);
        in_count++;
      end
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with no request pending, expected none, actual %0d %0d",
                   $time, speed_estimate, angle_estimate);
        end else begin
          want = estimate_q.pop_front();
          if (speed_estimate !== want.speed) note_mismatch("speed_estimate", want.speed,
                                                           speed_estimate);
          if (angle_estimate !== want.angle) note_mismatch("angle_estimate", want.angle,
                                                           angle_estimate);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold so the block backs up its input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && in_count >= PRESSURE_AT) begin
      pressure_done <= 1'b1;
      hold_left     <= PRESSURE_HOLD;
      out_ready     <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog: too long without any request moving on either port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                 ph, seg, k;
    logic signed [31:0] op_vd, op_vq, op_cd, op_cq;
    logic signed [31:0] vd, vq, cd, cq;
    stim_row_t          row;

    obs_cfg  = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 4'd2};
    speed_st = 0;
    angle_st = 0;

    // reset settings have a zero period: speed and angle stay at zero whatever comes in
    add_row(KEEP_CFG, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1);
    add_row(KEEP_CFG, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1);
    add_row(KEEP_CFG, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1);
    add_row(KEEP_CFG, W_MAX, W_MIN, W_MIN, W_MAX, 1'b1);
    add_row(KEEP_CFG, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b1);
    add_row(KEEP_CFG, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b1);
    // fast tracking: angle swings both ways, so the cross term flips sign
    add_row(CFG_TRACK, 32'sh0, 32'sh0003_0000, 32'sh0, 32'sh0, 1'b0);
    add_row(KEEP_CFG, 32'sh0, 32'shfffb_0000, 32'sh0, 32'sh0, 1'b0);
    add_row(KEEP_CFG, 32'sh0001_0000, 32'shfffe_0000, 32'sh0000_8000, 32'shffff_8000, 1'b0);
    add_row(KEEP_CFG, 32'sh0002_0000, 32'sh0004_0000, 32'shffff_0000, 32'sh0001_0000, 1'b0);
    // saturated speed, angle step of many turns
    add_row(KEEP_CFG, 32'sh0, W_MAX, 32'sh0, 32'sh0, 1'b0);
    add_row(KEEP_CFG, 32'sh0, W_MIN, 32'sh0, 32'sh0, 1'b0);
    add_row(KEEP_CFG, W_MAX, W_MIN, W_MAX, W_MIN, 1'b0);
    // every register at its top value
    add_row(CFG_MAXED, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0);
    add_row(KEEP_CFG, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0);
    add_row(KEEP_CFG, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
    add_row(KEEP_CFG, W_MIN, W_MAX, W_MAX, W_MIN, 1'b0);
    // every register at zero
    add_row(CFG_ZEROED, 32'sh1234_5678, 32'shedcb_a988, 32'sh0f0f_0f0f, 32'shf0f0_f0f1, 1'b0);
    add_row(KEEP_CFG, W_MAX, W_MIN, W_MAX, W_MIN, 1'b0);
    // typical drive operating points
    add_row(CFG_TYPICAL, 32'sh0010_0000, 32'sh00c8_0000, 32'sh0002_0000, 32'sh000a_0000, 1'b0);
    add_row(KEEP_CFG, 32'sh0010_0000, 32'sh00c8_0000, 32'sh0002_0000, 32'sh000a_0000, 1'b0);
    add_row(KEEP_CFG, 32'shfff0_0000, 32'shff38_0000, 32'shfffe_0000, 32'shfff6_0000, 1'b0);
    add_row(KEEP_CFG, 32'shfff0_0000, 32'shff38_0000, 32'shfffe_0000, 32'shfff6_0000, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.pick != KEEP_CFG) begin
        wait_idle();
        load_cfg(cfg_for(row.pick));
      end
      send_request(row.vd, row.vq, row.cd, row.cq, row.typed, row.speed, row.angle);
    end

    // random part: three idling mixes, a fresh register setting per segment
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < SEGS_PER_PHASE; seg++) begin
        wait_idle();
        if (ph == 0 && seg == 0) apb_write(SPARE_REG_IDX, $urandom);
        load_cfg(random_cfg($urandom_range(3) == 0));
        for (k = 0; k < SEG_ITEMS; k++) begin
          // hold an operating point for a while so speed settles and the angle turns
          if (k % 32 == 0) begin
            op_vd = rand_span(VOLT_SPAN);
            op_vq = rand_span(VOLT_SPAN);
            op_cd = rand_span(CURR_SPAN);
            op_cq = rand_span(CURR_SPAN);
          end
          if ($urandom_range(99) < 85) begin
            vd = op_vd + rand_span(VOLT_SPAN >> 6);
            vq = op_vq + rand_span(VOLT_SPAN >> 6);
            cd = op_cd + rand_span(CURR_SPAN >> 6);
            cq = op_cq + rand_span(CURR_SPAN >> 6);
          end else begin
            vd = rand_word(VOLT_SPAN);
            vq = rand_word(VOLT_SPAN);
            cd = rand_word(CURR_SPAN);
            cq = rand_word(CURR_SPAN);
          end
          send_request(vd, vq, cd, cq, 1'b0, '0, '0);
        end
      end
    end

    // drain, then give a stray result time to show up
    in_valid <= 1'b0;
    do @(posedge clk); while (estimate_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && estimate_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
